[rtl/mcd_pkg.sv]
// Shared types, constants and helpers for the multichannel CAN message deframer.
// No dependencies; every other rtl file refers to this package by scoped name.
package mcd_pkg;

  // Sizing
  localparam int Channels    = 4;
  localparam int BufferBytes = 256;
  localparam int ChW         = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int FillW       = $clog2(BufferBytes) + 1;
  localparam int MemDepth    = Channels * BufferBytes;
  localparam int MemAw       = $clog2(MemDepth);
  localparam int ApbAw       = 4;
  localparam int MaxBytes    = 8;

  // Channel modes
  typedef enum logic [1:0] {
    MODE_FREE   = 2'd0,
    MODE_STREAM = 2'd1,
    MODE_BUSY   = 2'd2
  } mode_e;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HDR_FIRST = 2'd0,
    REG_HDR_SECOND = 2'd1,
    REG_FTR_FIRST = 2'd2,
    REG_FTR_SECOND = 2'd3
  } reg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DISP = 2'd1,
    S_BYTE = 2'd2,
    S_DONE = 2'd3
  } state_e;

  // Reset values of the pattern registers
  localparam logic [7:0] HdrFirstRst  = 8'h55;
  localparam logic [7:0] HdrSecondRst = 8'hAA;
  localparam logic [7:0] FtrFirstRst  = 8'h66;
  localparam logic [7:0] FtrSecondRst = 8'hCC;

  typedef struct packed {
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] f1;
    logic [7:0] f2;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic byte_en;
    logic release_en;
    logic read_en;
    logic result_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    cnt_zero;
    logic    last_byte;
    logic    drop;
  } sts_t;

  // Message ids that are reported
  function automatic logic is_known_id(input logic [15:0] id);
    return (id == 16'h1002) || (id == 16'h1003) || (id == 16'h1009) ||
           (id == 16'h1007) || (id == 16'h0926) || (id == 16'h0909);
  endfunction

endpackage

[rtl/mcd_ctrl.sv]
// Sequencing controller of the deframer: accept, dispatch, byte loop, result.
// Depends on mcd_pkg; drives the command struct of mcd_dp.
module mcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  mcd_pkg::sts_t sts_i,
  output mcd_pkg::cmd_t cmd_o
);

  mcd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcd_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mcd_pkg::S_DISP;
      end
      mcd_pkg::S_DISP: begin
        if (sts_i.op == mcd_pkg::OP_FRAME && !sts_i.cnt_zero) state_d = mcd_pkg::S_BYTE;
        else state_d = mcd_pkg::S_DONE;
      end
      mcd_pkg::S_BYTE: begin
        if (sts_i.drop || sts_i.last_byte) state_d = mcd_pkg::S_DONE;
      end
      mcd_pkg::S_DONE: begin
        if (slot_free) state_d = mcd_pkg::S_IDLE;
      end
      default: state_d = mcd_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    cmd_o.load       = (state_q == mcd_pkg::S_IDLE) && in_valid_i;
    in_ready_o       = (state_q == mcd_pkg::S_IDLE);
    cmd_o.release_en = (state_q == mcd_pkg::S_DISP) && (sts_i.op == mcd_pkg::OP_RELEASE);
    cmd_o.read_en    = (state_q == mcd_pkg::S_DISP) && (sts_i.op == mcd_pkg::OP_READ);
    cmd_o.byte_en    = (state_q == mcd_pkg::S_BYTE);
    cmd_o.result_load = (state_q == mcd_pkg::S_DONE) && slot_free;
  end

  // Output slot: filled by a result, emptied when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == mcd_pkg::S_DISP))
    else $error("accepted item did not go to dispatch");
  a_byte_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcd_pkg::S_BYTE && !sts_i.last_byte && !sts_i.drop)
      |=> (state_q == mcd_pkg::S_BYTE))
    else $error("byte loop left early");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a waiting result");
`endif

endmodule

[rtl/mcd_dp.sv]
// Datapath of the deframer: item registers, channel state, byte step logic,
// buffer memory, counters and result registers. Depends on mcd_pkg.
module mcd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcd_pkg::cfg_t cfg_i,
  input  mcd_pkg::cmd_t cmd_i,
  output mcd_pkg::sts_t sts_o,
  input  logic [1:0]    opcode_i,
  input  logic [10:0]   frame_id_i,
  input  logic [3:0]    byte_count_i,
  input  logic [63:0]   frame_bytes_i,
  input  logic [1:0]    channel_select_i,
  input  logic [7:0]    read_offset_i,
  output logic          message_ready_o,
  output logic [1:0]    ready_channel_o,
  output logic [15:0]   ready_message_id_o,
  output logic [15:0]   ready_length_o,
  output logic          frame_dropped_o,
  output logic [7:0]    read_data_o,
  output logic [31:0]   dropped_total_o,
  output logic [31:0]   corrupted_total_o
);

  localparam int ChW   = mcd_pkg::ChW;
  localparam int FillW = mcd_pkg::FillW;
  localparam int MemAw = mcd_pkg::MemAw;

  // Item registers
  mcd_pkg::opcode_e op_q;
  logic [10:0] fid_q;
  logic [3:0]  cnt_q, idx_q;
  logic [63:0] data_q;
  logic [1:0]  sel_q;
  logic [7:0]  off_q;
  logic        ch_v_q;
  logic [ChW-1:0] ch_q;

  // Channel state
  mcd_pkg::mode_e mode_q [mcd_pkg::Channels];
  logic [10:0]      id_q   [mcd_pkg::Channels];
  logic [FillW-1:0] fill_q [mcd_pkg::Channels];
  logic [1:0]       hp_q   [mcd_pkg::Channels];
  logic [1:0]       fp_q   [mcd_pkg::Channels];
  logic [15:0]      mid_q  [mcd_pkg::Channels];
  logic [15:0]      len_q  [mcd_pkg::Channels];

  logic [31:0] drop_cnt_q, corrupt_cnt_q;

  // Per-item result
  logic        rdy_q, drp_q;
  logic [1:0]  rch_q;
  logic [15:0] rid_q, rlen_q;

  // Buffer memory
  logic [7:0] mem [mcd_pkg::MemDepth];
  logic [7:0] rd_q;

  logic [ChW-1:0] hit_idx, free_idx, cur_c;
  logic hit, free_hit, avail, take_id;
  mcd_pkg::mode_e m_n;
  logic [FillW-1:0] f0, f_n;
  logic [1:0]  hp_n, fp_n, corr;
  logic [15:0] mid_n, len_n;
  logic        rdy_now, wr_en;
  logic [7:0]  b;
  logic        sel_ok, off_ok;
  logic [MemAw-1:0] wr_addr, rd_addr;

  // Channel search: non-busy with same id first, then lowest free
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_hit = 1'b0; free_idx = '0;
    for (int c = mcd_pkg::Channels - 1; c >= 0; c--) begin
      if (mode_q[c] != mcd_pkg::MODE_BUSY && id_q[c] == fid_q) begin
        hit = 1'b1;
        hit_idx = ChW'(c);
      end
      if (mode_q[c] == mcd_pkg::MODE_FREE) begin
        free_hit = 1'b1;
        free_idx = ChW'(c);
      end
    end
    avail   = ch_v_q || hit || free_hit;
    take_id = !ch_v_q && !hit && free_hit;
    cur_c   = ch_v_q ? ch_q : (hit ? hit_idx : free_idx);
  end

  // One byte through buffer, header and footer detectors
  always_comb begin
    b       = data_q[7:0];
    m_n     = mode_q[cur_c];
    f0      = fill_q[cur_c];
    f_n     = f0;
    hp_n    = hp_q[cur_c];
    fp_n    = fp_q[cur_c];
    mid_n   = mid_q[cur_c];
    len_n   = len_q[cur_c];
    corr    = 2'd0;
    rdy_now = 1'b0;
    wr_en   = (m_n == mcd_pkg::MODE_STREAM);

    if (wr_en) begin
      // shadow copies of the id and length bytes
      if (f0 == FillW'(0)) mid_n[7:0] = b;
      if (f0 == FillW'(1)) mid_n[15:8] = b;
      if (f0 == FillW'(2)) len_n[7:0] = b;
      if (f0 == FillW'(3)) len_n[15:8] = b;
      f_n = f0 + FillW'(1);
      if (f_n >= FillW'(mcd_pkg::BufferBytes)) begin
        m_n = mcd_pkg::MODE_FREE; f_n = '0; hp_n = 2'd0; fp_n = 2'd0;
        corr = corr + 2'd1;
      end
      if (f_n > FillW'(3) && 17'(f_n) > ({1'b0, len_n} + 17'd8)) begin
        m_n = mcd_pkg::MODE_FREE; f_n = '0; hp_n = 2'd0; fp_n = 2'd0;
        corr = corr + 2'd1;
      end
    end

    // start pattern
    if (b == cfg_i.h1) begin
      hp_n = (hp_n == 2'd0) ? 2'd1 : ((hp_n == 2'd2) ? 2'd3 : 2'd0);
    end else if (b == cfg_i.h2) begin
      if (hp_n == 2'd1) hp_n = 2'd2;
      else if (hp_n == 2'd3) begin
        m_n = mcd_pkg::MODE_STREAM; f_n = '0; hp_n = 2'd0;
      end else hp_n = 2'd0;
    end else begin
      hp_n = 2'd0;
    end

    // end pattern
    if (b == cfg_i.f1) begin
      fp_n = (fp_n == 2'd0) ? 2'd1 : ((fp_n == 2'd2) ? 2'd3 : 2'd0);
    end else if (b == cfg_i.f2) begin
      if (fp_n == 2'd1) fp_n = 2'd2;
      else if (fp_n == 2'd3) begin
        if (f_n >= FillW'(8) && 17'(f_n) == ({1'b0, len_n} + 17'd8)) begin
          if (mcd_pkg::is_known_id(mid_n)) begin
            m_n = mcd_pkg::MODE_BUSY;
            rdy_now = 1'b1;
          end else begin
            m_n = mcd_pkg::MODE_FREE; f_n = '0; hp_n = 2'd0; fp_n = 2'd0;
          end
        end else begin
          m_n = mcd_pkg::MODE_FREE; f_n = '0; hp_n = 2'd0; fp_n = 2'd0;
          corr = corr + 2'd1;
        end
      end else fp_n = 2'd0;
    end else begin
      fp_n = 2'd0;
    end
  end

  // Buffer addressing
  assign sel_ok  = 32'(sel_q) < 32'(mcd_pkg::Channels);
  assign off_ok  = 32'(off_q) < 32'(mcd_pkg::BufferBytes);
  assign wr_addr = MemAw'(cur_c) * MemAw'(mcd_pkg::BufferBytes) + MemAw'(f0);
  assign rd_addr = (sel_ok && off_ok) ?
                   (MemAw'(sel_q) * MemAw'(mcd_pkg::BufferBytes) + MemAw'(off_q)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en && avail && wr_en) mem[wr_addr] <= b;
    if (cmd_i.read_en) rd_q <= mem[rd_addr];
  end

  // Item registers and byte loop bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= mcd_pkg::OP_NOP;
      fid_q <= '0; cnt_q <= '0; idx_q <= '0; data_q <= '0;
      sel_q <= '0; off_q <= '0; ch_v_q <= 1'b0; ch_q <= '0;
      rdy_q <= 1'b0; drp_q <= 1'b0; rch_q <= '0; rid_q <= '0; rlen_q <= '0;
      drop_cnt_q <= '0; corrupt_cnt_q <= '0;
    end else if (cmd_i.load) begin
      op_q   <= mcd_pkg::opcode_e'(opcode_i);
      fid_q  <= frame_id_i;
      cnt_q  <= (byte_count_i > 4'(mcd_pkg::MaxBytes)) ? 4'(mcd_pkg::MaxBytes) : byte_count_i;
      idx_q  <= '0;
      data_q <= frame_bytes_i;
      sel_q  <= channel_select_i;
      off_q  <= read_offset_i;
      ch_v_q <= 1'b0;
      rdy_q  <= 1'b0; drp_q <= 1'b0; rch_q <= '0; rid_q <= '0; rlen_q <= '0;
    end else if (cmd_i.byte_en) begin
      idx_q  <= idx_q + 4'd1;
      data_q <= {8'd0, data_q[63:8]};
      if (!avail) begin
        drop_cnt_q <= drop_cnt_q + 32'd1;
        drp_q      <= 1'b1;
      end else begin
        ch_q          <= cur_c;
        ch_v_q        <= !rdy_now;
        corrupt_cnt_q <= corrupt_cnt_q + 32'(corr);
        if (rdy_now) begin
          rdy_q  <= 1'b1;
          rch_q  <= 2'(cur_c);
          rid_q  <= mid_n;
          rlen_q <= len_n;
        end
      end
    end
  end

  // Channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mcd_pkg::Channels; c++) begin
        mode_q[c] <= mcd_pkg::MODE_FREE;
        id_q[c] <= '0; fill_q[c] <= '0; hp_q[c] <= '0; fp_q[c] <= '0;
        mid_q[c] <= '0; len_q[c] <= '0;
      end
    end else if (cmd_i.byte_en && avail) begin
      mode_q[cur_c] <= m_n;
      fill_q[cur_c] <= f_n;
      hp_q[cur_c]   <= hp_n;
      fp_q[cur_c]   <= fp_n;
      mid_q[cur_c]  <= mid_n;
      len_q[cur_c]  <= len_n;
      if (take_id) id_q[cur_c] <= fid_q;
    end else if (cmd_i.release_en && sel_ok) begin
      mode_q[ChW'(sel_q)] <= mcd_pkg::MODE_FREE;
      fill_q[ChW'(sel_q)] <= '0;
      hp_q[ChW'(sel_q)]   <= '0;
      fp_q[ChW'(sel_q)]   <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      message_ready_o    <= rdy_q;
      ready_channel_o    <= rch_q;
      ready_message_id_o <= rid_q;
      ready_length_o     <= rlen_q;
      frame_dropped_o    <= drp_q;
      read_data_o        <= (op_q == mcd_pkg::OP_READ && sel_ok && off_ok) ? rd_q : 8'd0;
      dropped_total_o    <= drop_cnt_q;
      corrupted_total_o  <= corrupt_cnt_q;
    end
  end

  // Status to controller
  assign sts_o.op        = op_q;
  assign sts_o.cnt_zero  = (cnt_q == 4'd0);
  assign sts_o.last_byte = ((idx_q + 4'd1) == cnt_q);
  assign sts_o.drop      = !avail;

`ifndef SYNTHESIS
  a_cnt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.byte_en |=> ($stable(drop_cnt_q) && $stable(corrupt_cnt_q)))
    else $error("counter moved outside the byte loop");
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.byte_en && avail && wr_en) |-> (f0 < FillW'(mcd_pkg::BufferBytes)))
    else $error("buffer write beyond channel area");
  a_busy_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q[0] == mcd_pkg::MODE_BUSY) |-> (fill_q[0] >= FillW'(8)))
    else $error("busy channel with short fill");
`endif

endmodule

[rtl/multichannel_can_message_deframer_top.sv]
// Sequence: an item is accepted in the idle state and dispatched in the next
// cycle; a CAN frame then takes one data byte per cycle (byte_count, at most
// 8, fewer if the frame is dropped) and then loads the output register once
// the output slot is free. Release, read and unused opcodes skip the byte
// loop, as does a frame with byte_count zero. The next item is accepted as
// soon as the result sits in the output register, even if not yet taken.
// Buffer reads go through the single registered read port of the buffer memory.
module multichannel_can_message_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [10:0] frame_id_i,
  input  logic [3:0]  byte_count_i,
  input  logic [63:0] frame_bytes_i,
  input  logic [1:0]  channel_select_i,
  input  logic [7:0]  read_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        message_ready_o,
  output logic [1:0]  ready_channel_o,
  output logic [15:0] ready_message_id_o,
  output logic [15:0] ready_length_o,
  output logic        frame_dropped_o,
  output logic [7:0]  read_data_o,
  output logic [31:0] dropped_total_o,
  output logic [31:0] corrupted_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mcd_pkg::ApbAw-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mcd_pkg::cfg_t cfg_q;
  mcd_pkg::cmd_t cmd;
  mcd_pkg::sts_t sts;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h1 <= mcd_pkg::HdrFirstRst;
      cfg_q.h2 <= mcd_pkg::HdrSecondRst;
      cfg_q.f1 <= mcd_pkg::FtrFirstRst;
      cfg_q.f2 <= mcd_pkg::FtrSecondRst;
    end else if (wr_en) begin
      unique case (mcd_pkg::reg_idx_e'(paddr[3:2]))
        mcd_pkg::REG_HDR_FIRST:  cfg_q.h1 <= pwdata[7:0];
        mcd_pkg::REG_HDR_SECOND: cfg_q.h2 <= pwdata[7:0];
        mcd_pkg::REG_FTR_FIRST:  cfg_q.f1 <= pwdata[7:0];
        mcd_pkg::REG_FTR_SECOND: cfg_q.f2 <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (mcd_pkg::reg_idx_e'(paddr[3:2]))
      mcd_pkg::REG_HDR_FIRST:  prdata = {24'd0, cfg_q.h1};
      mcd_pkg::REG_HDR_SECOND: prdata = {24'd0, cfg_q.h2};
      mcd_pkg::REG_FTR_FIRST:  prdata = {24'd0, cfg_q.f1};
      mcd_pkg::REG_FTR_SECOND: prdata = {24'd0, cfg_q.f2};
      default:                 prdata = '0;
    endcase
  end

  mcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .frame_id_i         (frame_id_i),
    .byte_count_i       (byte_count_i),
    .frame_bytes_i      (frame_bytes_i),
    .channel_select_i   (channel_select_i),
    .read_offset_i      (read_offset_i),
    .message_ready_o    (message_ready_o),
    .ready_channel_o    (ready_channel_o),
    .ready_message_id_o (ready_message_id_o),
    .ready_length_o     (ready_length_o),
    .frame_dropped_o    (frame_dropped_o),
    .read_data_o        (read_data_o),
    .dropped_total_o    (dropped_total_o),
    .corrupted_total_o  (corrupted_total_o)
  );

endmodule
